// ----- hw/rtl/swvq_pkg.sv -----
// shared types and constants of the sorted wrap-around visit queue
`default_nettype none

package swvq_pkg;

    localparam int unsigned QueueDepthDefault = 8;
    localparam int unsigned StationW          = 8;
    localparam int unsigned ListSizeW         = 4;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_DONE  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    // controller to datapath
    typedef struct packed {
        logic accept;   // latch the request fields
        logic exec;     // apply the latched action
        logic search;   // one step of the wrap start search
        logic capture;  // register the result fields
    } t_swvq_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_search;  // latched request closes a list
        logic search_done;  // wrap start settled this cycle
    } t_swvq_status;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_wraparound_visit_queue_unit.sv -----
// top level of the sorted wrap-around visit queue
//
//  channel   direction  handshake               payload
//  request   in         start, busy             i_action, i_station, i_last_station
//  result    out        o_strobe (one cycle)    o_next_station, o_mission_active,
//                                               o_going_home, o_all_done, o_list_size
//  config    in         i_cfg_we                i_cfg_wdata (current position)
//
// a request passes through the execute and capture states to the result strobe; a load
// that closes the list adds a wrap start search between them, one stored station
// compared per cycle through the single read port of the station store
// busy is high from the accepting edge until the strobe cycle, in which a new
// request may already be accepted
// reset is synchronous, active low, and empties the list
// the receiver cannot stall: each result is valid for exactly the strobe cycle
`default_nettype none

module sorted_wraparound_visit_queue_unit
    import swvq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_action,
    input  wire logic [StationW-1:0]  i_station,
    input  wire logic                 i_last_station,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [StationW-1:0]  i_cfg_wdata,
    // result
    output logic                      o_strobe,
    output logic [StationW-1:0]       o_next_station,
    output logic                      o_mission_active,
    output logic                      o_going_home,
    output logic                      o_all_done,
    output logic [ListSizeW-1:0]      o_list_size
);

    t_swvq_cmd    cmd;
    t_swvq_status status;

    // sequencing: accept, execute, optional search, capture and strobe
    swvq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // station store with insertion cells, visit pointers and result registers
    swvq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_action         (i_action),
        .i_station        (i_station),
        .i_last_station   (i_last_station),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_next_station   (o_next_station),
        .o_mission_active (o_mission_active),
        .o_going_home     (o_going_home),
        .o_all_done       (o_all_done),
        .o_list_size      (o_list_size)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/swvq_ctrl.sv -----
// controller state machine of the visit queue
`default_nettype none

module swvq_ctrl
    import swvq_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    output logic              o_strobe,
    output t_swvq_cmd         o_cmd,
    input  wire t_swvq_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH,
        S_CAPT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

    always_comb begin
        o_cmd         = '0;
        o_cmd.accept  = (r_state == S_IDLE) && start && !r_busy;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.search  = (r_state == S_SRCH);
        o_cmd.capture = (r_state == S_CAPT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start && !r_busy) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= i_status.need_search ? S_SRCH : S_CAPT;
                end
                S_SRCH: begin
                    if (i_status.search_done) begin
                        r_state <= S_CAPT;
                    end
                end
                S_CAPT: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/swvq_dp.sv -----
// datapath of the visit queue: insertion cells, pointers and result registers
`default_nettype none

module swvq_dp
    import swvq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_swvq_cmd            i_cmd,
    output t_swvq_status              o_status,
    input  wire logic [1:0]           i_action,
    input  wire logic [StationW-1:0]  i_station,
    input  wire logic                 i_last_station,
    input  wire logic                 i_cfg_we,
    input  wire logic [StationW-1:0]  i_cfg_wdata,
    output logic [StationW-1:0]       o_next_station,
    output logic                      o_mission_active,
    output logic                      o_going_home,
    output logic                      o_all_done,
    output logic [ListSizeW-1:0]      o_list_size
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

    // latched request and the position register
    t_action               r_action;
    logic [StationW-1:0]   r_station;
    logic                  r_last;
    logic [StationW-1:0]   r_pos;

    // queue state
    logic [StationW-1:0]   r_ent [QUEUE_DEPTH];
    logic [StationW-1:0]   n_ent [QUEUE_DEPTH];
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_visit, n_visit;
    logic [CW-1:0]         r_wrap,  n_wrap;
    logic [CW-1:0]         r_idx,   n_idx;
    logic                  r_active, n_active;
    logic                  r_home,   n_home;
    logic                  r_loading, n_loading;

    // result registers
    logic [StationW-1:0]   r_next;
    logic                  r_res_active;
    logic                  r_res_home;
    logic                  r_res_done;
    logic [CW-1:0]         r_res_size;

    logic [CW-1:0]         cnt_eff;
    logic [QUEUE_DEPTH-1:0] le;
    logic [StationW-1:0]   ins [QUEUE_DEPTH];
    logic [CW-1:0]         visit_inc;
    logic [CW:0]           k_sum;
    logic [CW-1:0]         k_idx;
    logic [CW-1:0]         rd_addr;
    logic [StationW-1:0]   rd_data;
    logic                  search_hit;
    logic                  search_zero;

    assign cnt_eff = r_loading ? r_count : '0;

    // compare-and-shift cells: each slot keeps, takes the new station or takes its neighbour
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le[i] = (CW'(i) < cnt_eff) && (r_ent[i] <= r_station);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (le[i]) begin
                ins[i] = r_ent[i];
            end else if (i == 0) begin
                ins[i] = r_station;
            end else if (le[(i > 0) ? i - 1 : 0]) begin
                ins[i] = r_station;
            end else begin
                ins[i] = r_ent[(i > 0) ? i - 1 : 0];
            end
        end
    end

    // rotated read position
    always_comb begin
        k_sum = {1'b0, r_wrap} + {1'b0, r_visit};
        if (k_sum >= {1'b0, r_count}) begin
            k_sum = k_sum - {1'b0, r_count};
        end
        k_idx = k_sum[CW-1:0];
    end

    // one shared read port, search pointer or rotated index
    assign rd_addr = i_cmd.search ? r_idx : k_idx;
    always_comb begin
        if (rd_addr < DepthC) begin
            rd_data = r_ent[rd_addr[IW-1:0]];
        end else begin
            rd_data = '0;
        end
    end

    assign search_zero = (r_pos == '0) || (r_idx >= r_count);
    assign search_hit  = search_zero || (rd_data > r_pos);

    assign o_status.need_search = (r_action == ACT_LOAD) && r_last;
    assign o_status.search_done = search_hit;

    assign visit_inc = (r_visit < r_count) ? r_visit + CW'(1) : r_visit;

    always_comb begin
        n_ent     = r_ent;
        n_count   = r_count;
        n_visit   = r_visit;
        n_wrap    = r_wrap;
        n_idx     = r_idx;
        n_active  = r_active;
        n_home    = r_home;
        n_loading = r_loading;
        if (i_cmd.exec) begin
            case (r_action)
                ACT_LOAD: begin
                    if (!r_loading) begin
                        n_visit   = '0;
                        n_wrap    = '0;
                        n_active  = 1'b0;
                        n_home    = 1'b0;
                        n_loading = 1'b1;
                    end
                    n_count = cnt_eff;
                    if (cnt_eff < DepthC) begin
                        n_ent   = ins;
                        n_count = cnt_eff + CW'(1);
                    end
                    if (r_last) begin
                        n_loading = 1'b0;
                        n_visit   = '0;
                        n_active  = 1'b1;
                        n_home    = 1'b0;
                        n_idx     = '0;
                    end
                end
                ACT_DONE: begin
                    n_visit = visit_inc;
                    if (visit_inc >= r_count) begin
                        n_home   = 1'b1;
                        n_active = 1'b0;
                    end
                end
                ACT_CLEAR: begin
                    for (int i = 0; i < QUEUE_DEPTH; i++) begin
                        n_ent[i] = '0;
                    end
                    n_count   = '0;
                    n_visit   = '0;
                    n_wrap    = '0;
                    n_active  = 1'b0;
                    n_home    = 1'b0;
                    n_loading = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.search) begin
            if (search_hit) begin
                n_wrap = search_zero ? '0 : r_idx;
            end else begin
                n_idx = r_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_ent[i] <= '0;
            end
            r_count      <= '0;
            r_visit      <= '0;
            r_wrap       <= '0;
            r_idx        <= '0;
            r_active     <= 1'b0;
            r_home       <= 1'b0;
            r_loading    <= 1'b0;
            r_pos        <= '0;
            r_action     <= ACT_QUERY;
            r_next       <= '0;
            r_res_active <= 1'b0;
            r_res_home   <= 1'b0;
            r_res_done   <= 1'b0;
            r_res_size   <= '0;
        end else begin
            r_ent     <= n_ent;
            r_count   <= n_count;
            r_visit   <= n_visit;
            r_wrap    <= n_wrap;
            r_idx     <= n_idx;
            r_active  <= n_active;
            r_home    <= n_home;
            r_loading <= n_loading;
            if (i_cfg_we) begin
                r_pos <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_action <= t_action'(i_action);
            end
            if (i_cmd.capture) begin
                r_next       <= (r_visit < r_count) ? rd_data : '0;
                r_res_active <= r_active;
                r_res_home   <= r_home;
                r_res_done   <= (r_visit >= r_count);
                r_res_size   <= r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_station <= i_station;
            r_last    <= i_last_station;
        end
    end

    assign o_next_station   = r_next;
    assign o_mission_active = r_res_active;
    assign o_going_home     = r_res_home;
    assign o_all_done       = r_res_done;
    assign o_list_size      = ListSizeW'(r_res_size);

endmodule

`default_nettype wire

// ----- tb/sv/sorted_wraparound_visit_queue_unit_tb.sv -----
// self-checking testbench of the sorted wrap-around visit queue unit
module sorted_wraparound_visit_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swvq_pkg::*;

    localparam int unsigned Depth         = QueueDepthDefault;
    localparam int unsigned RandomItems   = 600;
    // the worst request plus a sender gap stays far below this limit, so it is generous
    localparam int unsigned WatchdogLimit = 2000;

    // one result as the block reports it
    typedef struct packed {
        logic [StationW-1:0]  next_station;
        logic                 mission_active;
        logic                 going_home;
        logic                 all_done;
        logic [ListSizeW-1:0] list_size;
    } t_visit_result;

    // stimulus side, every input known from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic [1:0]          i_action       = ACT_QUERY;
    logic [StationW-1:0] i_station      = '0;
    logic                i_last_station = 1'b0;
    logic                i_cfg_we       = 1'b0;
    logic [StationW-1:0] i_cfg_wdata    = '0;

    wire                 busy;
    wire                 o_strobe;
    wire [StationW-1:0]  o_next_station;
    wire                 o_mission_active;
    wire                 o_going_home;
    wire                 o_all_done;
    wire [ListSizeW-1:0] o_list_size;

    // visit list as the testbench expects it to be
    logic [StationW-1:0] stn_store [Depth];
    int unsigned         stn_count;
    int unsigned         visited;
    int unsigned         first_idx;
    bit                  on_mission;
    bit                  heading_home;
    bit                  list_open;
    logic [StationW-1:0] dock_pos;

    // results still owed by the block, oldest first
    t_visit_result       expected_visits [$];
    t_visit_result       seen_visit;
    t_visit_result       owed_visit;

    int unsigned         fail_count   = 0;
    int unsigned         sent_count   = 0;
    int unsigned         stall_cycles = 0;
    bit                  gaps_on      = 1'b1;

    sorted_wraparound_visit_queue_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_station        (i_station),
        .i_last_station   (i_last_station),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_strobe         (o_strobe),
        .o_next_station   (o_next_station),
        .o_mission_active (o_mission_active),
        .o_going_home     (o_going_home),
        .o_all_done       (o_all_done),
        .o_list_size      (o_list_size)
    );

    always #5ns i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    // empties the list and every flag, the position register is kept
    function automatic void clear_visit_list();
        for (int unsigned k = 0; k < Depth; k++) begin
            stn_store[k] = '0;
        end
        stn_count    = 0;
        visited      = 0;
        first_idx    = 0;
        on_mission   = 1'b0;
        heading_home = 1'b0;
        list_open    = 1'b0;
    endfunction

    // applies one request to the expected list and returns the result it owes
    function automatic t_visit_result advance_visit_list(input t_action act,
                                                         input logic [StationW-1:0] stn,
                                                         input logic last);
        t_visit_result r;
        int unsigned   slot;
        int unsigned   k;
        case (act)
            ACT_LOAD: begin
                // first load after a closed list starts a fresh one
                if (!list_open) begin
                    stn_count    = 0;
                    visited      = 0;
                    first_idx    = 0;
                    on_mission   = 1'b0;
                    heading_home = 1'b0;
                    list_open    = 1'b1;
                end
                // sorted insert, equal stations go behind the stored ones,
                // a station beyond capacity is dropped
                if (stn_count < Depth) begin
                    slot = 0;
                    while (slot < stn_count && stn_store[slot] <= stn) begin
                        slot++;
                    end
                    for (k = stn_count; k > slot; k--) begin
                        stn_store[k] = stn_store[k-1];
                    end
                    stn_store[slot] = stn;
                    stn_count++;
                end
                // closing the list: visiting starts at the lowest station above
                // the position, or at the lowest station when there is none or the position is zero
                if (last) begin
                    list_open    = 1'b0;
                    visited      = 0;
                    first_idx    = 0;
                    on_mission   = 1'b1;
                    heading_home = 1'b0;
                    if (dock_pos != '0) begin
                        for (k = stn_count; k > 0; k--) begin
                            if (stn_store[k-1] > dock_pos) first_idx = k - 1;
                        end
                    end
                end
            end
            ACT_DONE: begin
                // saturating advance, going home whenever the index sits at the end
                if (visited < stn_count) visited++;
                if (visited >= stn_count) begin
                    heading_home = 1'b1;
                    on_mission   = 1'b0;
                end
            end
            ACT_CLEAR: begin
                clear_visit_list();
            end
            default: begin
            end
        endcase

        r.next_station = '0;
        if (visited < stn_count) begin
            k = first_idx + visited;
            if (k >= stn_count) k -= stn_count;
            if (k < Depth) r.next_station = stn_store[k];
        end
        r.mission_active = on_mission;
        r.going_home     = heading_home;
        r.all_done       = (visited >= stn_count);
        r.list_size      = ListSizeW'(stn_count);
        return r;
    endfunction

    function automatic void log_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%0t ns: %s", $time, what);
    endfunction

    // ---------------------------------------------------------------- checking

    // each strobe is compared with the oldest result owed; the same block keeps
    // the watchdog, which counts edges with neither a request nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            if (o_strobe) begin
                seen_visit = '{o_next_station, o_mission_active, o_going_home,
                               o_all_done, o_list_size};
                if (expected_visits.size() == 0) begin
                    log_failure($sformatf("result with no request owed: %p", seen_visit));
                end else begin
                    owed_visit = expected_visits.pop_front();
                    if (seen_visit.next_station   !== owed_visit.next_station   ||
                        seen_visit.mission_active !== owed_visit.mission_active ||
                        seen_visit.going_home     !== owed_visit.going_home     ||
                        seen_visit.all_done       !== owed_visit.all_done       ||
                        seen_visit.list_size      !== owed_visit.list_size) begin
                        log_failure($sformatf("mismatch, expected %p, got %p",
                                              owed_visit, seen_visit));
                    end
                end
            end
            if (o_strobe || (start && !busy)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WatchdogLimit) begin
                $display("sorted_wraparound_visit_queue_unit_tb: done, errors");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // offers one request and returns at the edge that takes it; start is left
    // high so that a back-to-back request needs no second assignment
    task automatic send_request(input t_action act, input logic [StationW-1:0] stn,
                                input logic last);
        if (gaps_on && $urandom_range(99) < 9) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= act;
        i_station      <= stn;
        i_last_station <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_visits.push_back(advance_visit_list(act, stn, last));
        sent_count++;
    endtask

    // holds requests back until every owed result has come
    task automatic settle_all();
        start <= 1'b0;
        while (expected_visits.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // position register written only with the block idle
    task automatic write_position(input logic [StationW-1:0] pos);
        settle_all();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pos;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dock_pos     = pos;
    endtask

    // query and completion on an empty block, completion while a list is open,
    // equal stations, saturation at the end and a clear of an open list
    task automatic test_basic_actions();
        write_position(8'd0);
        send_request(ACT_QUERY, 8'd0,   1'b0);
        send_request(ACT_DONE,  8'hFF,  1'b1);
        send_request(ACT_LOAD,  8'hFF,  1'b0);
        send_request(ACT_LOAD,  8'd0,   1'b0);
        send_request(ACT_DONE,  8'd0,   1'b0);
        send_request(ACT_LOAD,  8'd0,   1'b1);
        repeat (4) send_request(ACT_DONE, 8'd0, 1'b0);
        send_request(ACT_LOAD,  8'd7,   1'b0);
        send_request(ACT_CLEAR, 8'hAA,  1'b1);
        send_request(ACT_QUERY, 8'h55,  1'b1);
    endtask

    // nine stations into eight slots, the dropped one still closes the list;
    // stations equal to the position do not count as above it
    task automatic test_overfull_list();
        logic [StationW-1:0] stations [8] = '{8'd150, 8'd20, 8'd100, 8'd101,
                                              8'd99, 8'd250, 8'd100, 8'd3};
        write_position(8'd100);
        foreach (stations[k]) send_request(ACT_LOAD, stations[k], 1'b0);
        send_request(ACT_LOAD, 8'd77, 1'b1);
        send_request(ACT_DONE, 8'd0,  1'b0);
    endtask

    // top position, no station above it
    task automatic test_position_extremes();
        write_position(8'hFF);
        send_request(ACT_LOAD, 8'd200, 1'b0);
        send_request(ACT_LOAD, 8'hFF,  1'b1);
        send_request(ACT_DONE, 8'd0,   1'b0);
    endtask

    // mostly complete lists with random stations followed by completions,
    // the rest clears, lists cut short and random noise
    task automatic test_random_traffic();
        int unsigned         base;
        int unsigned         n_load;
        int unsigned         n_done;
        int unsigned         pick;
        logic [StationW-1:0] stn;
        base = sent_count;
        while (sent_count < base + RandomItems) begin
            // a long stretch in the middle with no sender gaps at all
            gaps_on = !((sent_count - base) >= 200 && (sent_count - base) < 350);

            pick = $urandom_range(99);
            if (pick < 6) begin
                write_position(8'd0);
            end else if (pick < 12) begin
                write_position(8'hFF);
            end else if (pick < 22) begin
                write_position(8'($urandom_range(255)));
            end else if (pick < 26) begin
                write_position(8'($urandom_range(1, 6)));
            end else if (pick >= 96) begin
                settle_all();
            end

            pick = $urandom_range(99);
            if (pick < 70) begin
                // well-formed list, now and then overfull
                n_load = ($urandom_range(9) == 0) ? $urandom_range(9, 11)
                                                  : $urandom_range(1, Depth);
                for (int unsigned k = 0; k < n_load; k++) begin
                    case ($urandom_range(2))
                        0:       stn = 8'($urandom_range(255));
                        1:       stn = dock_pos + 8'($urandom_range(4)) - 8'd2;
                        default: stn = 8'($urandom_range(7));
                    endcase
                    if ($urandom_range(19) == 0) begin
                        send_request(ACT_QUERY, 8'($urandom_range(255)), 1'($urandom));
                    end
                    send_request(ACT_LOAD, stn, k == n_load - 1);
                end
                n_done = $urandom_range(0, n_load + 2);
                for (int unsigned k = 0; k < n_done; k++) begin
                    send_request(ACT_DONE, 8'($urandom_range(255)), 1'($urandom));
                end
            end else if (pick < 82) begin
                // list left open, then cleared
                repeat ($urandom_range(0, 3)) begin
                    send_request(ACT_LOAD, 8'($urandom_range(255)), 1'b0);
                end
                send_request(ACT_CLEAR, 8'($urandom_range(255)), 1'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_request(t_action'($urandom_range(3)),
                                 8'($urandom_range(255)), 1'($urandom));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        clear_visit_list();
        dock_pos = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_actions();
        test_overfull_list();
        test_position_extremes();
        test_random_traffic();

        // drain, then a few more edges for any stray strobe
        settle_all();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sorted_wraparound_visit_queue_unit_tb: done, clean");
        end else begin
            $display("sorted_wraparound_visit_queue_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/swvq_pkg.sv
hw/rtl/swvq_ctrl.sv
hw/rtl/swvq_dp.sv
hw/rtl/sorted_wraparound_visit_queue_unit.sv
tb/sv/sorted_wraparound_visit_queue_unit_tb.sv
